>>> design/utf8vd_pkg.sv
// utf8vd_pkg: types, constants and byte classification for the utf-8 decoder
// no dependencies; imported by utf8_validating_decoder
package utf8vd_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [CP_W-1:0] REPL_CP      = 21'h00FFFD;
  localparam logic [CP_W-1:0] MIN_TWO_CP   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_THREE_CP = 21'h000800;
  localparam logic [CP_W-1:0] MIN_FOUR_CP  = 21'h010000;
  localparam logic [CP_W-1:0] SURR_LO_CP   = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI_CP   = 21'h00DFFF;
  localparam logic [CP_W-1:0] MAX_CP       = 21'h10FFFF;

  localparam logic [1:0] TAIL_ONE   = 2'd1;
  localparam logic [1:0] TAIL_TWO   = 2'd2;
  localparam logic [1:0] TAIL_THREE = 2'd3;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  function automatic lead_kind_t classify_lead(input logic [7:0] b);
    lead_kind_t k;
    if (b inside {[8'h00:8'h7F]}) begin
      k = LEAD_ASCII;
    end else if (b inside {[8'hC2:8'hDF]}) begin
      k = LEAD_TWO;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      k = LEAD_THREE;
    end else if (b inside {[8'hF0:8'hF4]}) begin
      k = LEAD_FOUR;
    end else begin
      k = LEAD_BAD;
    end
    return k;
  endfunction

  function automatic logic is_continuation(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // overlong, surrogate or out of range
  function automatic logic seq_invalid(input logic [CP_W-1:0] v, input logic [1:0] tails);
    logic overlong;
    overlong = ((tails == TAIL_ONE)   && (v < MIN_TWO_CP)) ||
               ((tails == TAIL_TWO)   && (v < MIN_THREE_CP)) ||
               ((tails == TAIL_THREE) && (v < MIN_FOUR_CP));
    return overlong || ((v >= SURR_LO_CP) && (v <= SURR_HI_CP)) || (v > MAX_CP);
  endfunction

endpackage

>>> design/utf8_validating_decoder.sv
// utf8_validating_decoder: utf-8 byte stream to unicode scalar values with U+FFFD
// depends on utf8vd_pkg
//
// usage:
//   input channel  in_valid/in_ready, payload in_byte and in_string_end
//   (set on the last byte of a string)
//   output channel out_valid/out_ready, payload out_code_point, out_run_last
//   (last result of one input byte) and out_text_last (last result of a string)
//   each byte request is decoded in the cycle it is accepted; its results are
//   loaded into the result register and appear on the output from the next cycle
//   a byte gives zero to four results; one result per cycle leaves the block
//   while out_ready is high; throughput is then one byte per cycle while each
//   byte gives at most one result; a byte giving n > 1 results holds in_ready
//   low while the result register drains its replacement characters
//   a new byte is accepted in the cycle the final pending result is taken
//   when out_ready is low the result register holds and in_ready drops once
//   a result is pending
//   reset (rst_n low, synchronous) drops any open sequence and pending results
module utf8_validating_decoder
  import utf8vd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_string_end,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_run_last,
  output logic            out_text_last
);

  logic [1:0]       exp_r, exp_nxt;
  logic [1:0]       rcv_r, rcv_nxt;
  logic [CP_W-1:0]  pv_r, pv_nxt;

  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] rep_r;
  logic [CP_W-1:0]  tail_r;
  logic             last_r;

  logic [CNT_W-1:0] reps;
  logic             has_tail;
  logic [CP_W-1:0]  tail_val;
  logic             lead_path;
  logic [CP_W-1:0]  shifted;
  logic [2:0]       rsum;
  lead_kind_t       kind;

  logic in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (rem_r == '0) || (out_ready && (rem_r == CNT_W'(1)));

  assign kind    = classify_lead(in_byte);
  assign shifted = {pv_r[CP_W-7:0], in_byte[5:0]};
  assign rsum    = {1'b0, rcv_r} + 3'd1;

  always_comb begin
    exp_nxt   = exp_r;
    rcv_nxt   = rcv_r;
    pv_nxt    = pv_r;
    reps      = '0;
    has_tail  = 1'b0;
    tail_val  = {{(CP_W-8){1'b0}}, in_byte};
    lead_path = 1'b0;

    if (exp_r == 2'd0) begin
      lead_path = 1'b1;
    end else if (is_continuation(in_byte)) begin
      if (rsum >= {1'b0, exp_r}) begin
        exp_nxt = 2'd0;
        rcv_nxt = 2'd0;
        pv_nxt  = '0;
        if (seq_invalid(shifted, exp_r)) begin
          reps = CNT_W'(1) + CNT_W'(exp_r);
        end else begin
          has_tail = 1'b1;
          tail_val = shifted;
        end
      end else begin
        rcv_nxt = rsum[1:0];
        pv_nxt  = shifted;
      end
    end else begin
      // abandoned sequence: lead and each buffered continuation
      reps      = CNT_W'(1) + CNT_W'(rcv_r);
      exp_nxt   = 2'd0;
      rcv_nxt   = 2'd0;
      pv_nxt    = '0;
      lead_path = 1'b1;
    end

    if (lead_path) begin
      case (kind)
        LEAD_ASCII: begin
          has_tail = 1'b1;
        end
        LEAD_TWO: begin
          exp_nxt = TAIL_ONE;
          rcv_nxt = 2'd0;
          pv_nxt  = {{(CP_W-5){1'b0}}, in_byte[4:0]};
        end
        LEAD_THREE: begin
          exp_nxt = TAIL_TWO;
          rcv_nxt = 2'd0;
          pv_nxt  = {{(CP_W-4){1'b0}}, in_byte[3:0]};
        end
        LEAD_FOUR: begin
          exp_nxt = TAIL_THREE;
          rcv_nxt = 2'd0;
          pv_nxt  = {{(CP_W-3){1'b0}}, in_byte[2:0]};
        end
        default: begin
          reps = reps + CNT_W'(1);
        end
      endcase
    end

    // truncated at string end
    if (in_string_end && (exp_nxt != 2'd0)) begin
      reps    = reps + CNT_W'(1) + CNT_W'(rcv_nxt);
      exp_nxt = 2'd0;
      rcv_nxt = 2'd0;
      pv_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
      rcv_r <= '0;
      pv_r  <= '0;
      rem_r <= '0;
      rep_r <= '0;
    end else begin
      if (in_fire) begin
        exp_r <= exp_nxt;
        rcv_r <= rcv_nxt;
        pv_r  <= pv_nxt;
        rem_r <= reps + CNT_W'(has_tail);
        rep_r <= reps;
      end else if (out_fire) begin
        rem_r <= rem_r - CNT_W'(1);
        if (rep_r != '0) begin
          rep_r <= rep_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tail_r <= tail_val;
      last_r <= in_string_end;
    end
  end

  assign out_valid      = (rem_r != '0);
  assign out_code_point = (rep_r != '0) ? REPL_CP : tail_r;
  assign out_run_last   = (rem_r == CNT_W'(1));
  assign out_text_last  = out_run_last && last_r;

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_string_end |=> out_valid)
    else $error("string end request produced no result");

  a_end_closes_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_string_end |=> (exp_r == 2'd0))
    else $error("sequence left open after string end");

  a_tail_count: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r == 2'd0) ? (rcv_r == 2'd0) : (rcv_r < exp_r))
    else $error("received tail count out of step with expected");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rep_r <= rem_r) && (rem_r <= CNT_W'(MAX_RESULTS)))
    else $error("pending result counters inconsistent");

endmodule
